// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the compacting_id_registry RTL file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while in reset.
`define CIDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("registry check failed");

// Next-cycle implication, sampled on i_clk and disabled while in reset.
`define CIDR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("registry check failed");

`endif

// ===== hw/rtl/cidr_pkg.sv =====
// ---------------------------------------------------------------------------
// cidr_pkg
// Shared constants and types of the compacting identifier registry.
// ---------------------------------------------------------------------------
package cidr_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 22;

    localparam int KIND_W   = 2;
    localparam int IDENT_W  = 22;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;
    localparam int WIDE_W   = 32;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_REG    = 2'd0;
    localparam t_kind KIND_REMOVE = 2'd1;
    localparam t_kind KIND_READ   = 2'd2;
    localparam t_kind KIND_NONE   = 2'd3;

    localparam t_status ST_STORED   = 3'd0;
    localparam t_status ST_PRESENT  = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_REMOVED  = 3'd3;
    localparam t_status ST_NOTFOUND = 3'd4;
    localparam t_status ST_READ     = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

endpackage

// ===== hw/rtl/cidr_store.sv =====
// ---------------------------------------------------------------------------
// cidr_store
// Slot memory with one write and one read port, registered read data and
// a valid bit per slot so that unwritten slots read as empty after reset.
// ---------------------------------------------------------------------------
module cidr_store #(
    parameter int SLOTS = cidr_pkg::SLOTS_DEF,
    parameter int WIDTH = cidr_pkg::ID_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(SLOTS)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(SLOTS)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== hw/rtl/compacting_id_registry.sv =====
// ---------------------------------------------------------------------------
// compacting_id_registry
// Table of nonzero identifiers kept packed at the low slots. Requests
// register, remove (with compaction) or read out the whole table.
//
// Channel   Direction  Handshake          Fields
// request   in         start, busy        i_kind, i_ident
// result    out        o_strobe           o_status, o_slot_index,
//                                         o_slot_value, o_last
//
// A request is taken when start is high and busy is low. A register or
// remove of a nonzero identifier walks the slot memory one slot per cycle,
// and a compacting remove ends with a final clear of the last slot; a
// read gives one result per cycle. A register or remove of a zero
// identifier is answered in the cycle after the request, without a scan.
// Reset clears the per-slot valid bits. Results are not held.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module compacting_id_registry #(
    parameter int SLOTS   = cidr_pkg::SLOTS_DEF,
    parameter int ID_BITS = cidr_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [cidr_pkg::KIND_W-1:0]   i_kind,
    input  logic [cidr_pkg::IDENT_W-1:0]  i_ident,
    output logic                          busy,
    output logic                          o_strobe,
    output logic [cidr_pkg::STATUS_W-1:0] o_status,
    output logic [cidr_pkg::INDEX_W-1:0]  o_slot_index,
    output logic [cidr_pkg::IDENT_W-1:0]  o_slot_value,
    output logic                          o_last
);

    import cidr_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    t_state           r_state, n_state;
    t_kind            r_kind, n_kind;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [AW-1:0]    r_didx, n_didx;
    logic [AW-1:0]    r_pos, n_pos;
    logic             r_found, n_found;

    logic             r_strobe, n_strobe;
    t_status          r_status, n_status;
    logic [AW-1:0]    r_index, n_index;
    logic [ID_BITS-1:0] r_value, n_value;
    logic             r_last, n_last;

    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [ID_BITS-1:0] w_wdata, w_rdata;

    logic             w_accept, w_last, w_match, w_empty;
    logic [WIDE_W-1:0] w_ident_wide, w_index_wide, w_value_wide;
    logic [ID_BITS-1:0] w_id_in;

    cidr_store #(
        .SLOTS (SLOTS),
        .WIDTH (ID_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ident_wide = WIDE_W'(i_ident);
    assign w_id_in      = w_ident_wide[ID_BITS-1:0];
    assign w_accept     = start && (r_state == S_IDLE);
    assign w_last       = (r_didx == LAST_IDX);
    assign w_match      = (w_rdata == r_id);
    assign w_empty      = (w_rdata == '0);

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_id     = r_id;
        n_didx   = r_didx;
        n_pos    = r_pos;
        n_found  = r_found;
        n_strobe = 1'b0;
        n_status = r_status;
        n_index  = r_index;
        n_value  = r_value;
        n_last   = r_last;
        w_we     = 1'b0;
        w_waddr  = r_didx;
        w_wdata  = '0;
        w_re     = 1'b0;
        w_raddr  = r_didx + 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_kind;
                    n_id    = w_id_in;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_didx  = '0;
                    case (i_kind)
                        KIND_REG, KIND_REMOVE: begin
                            if (w_id_in == '0) begin
                                n_strobe = 1'b1;
                                n_status = (i_kind == KIND_REG) ? ST_FULL : ST_NOTFOUND;
                                n_index  = '0;
                                n_value  = w_id_in;
                                n_last   = 1'b1;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_READ: begin
                            w_re    = 1'b1;
                            w_raddr = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!w_last) begin
                    w_re   = 1'b1;
                    n_didx = r_didx + 1'b1;
                end
                case (r_kind)
                    KIND_READ: begin
                        n_strobe = 1'b1;
                        n_status = ST_READ;
                        n_index  = r_didx;
                        n_value  = w_rdata;
                        n_last   = w_last;
                        if (w_last) begin
                            n_state = S_IDLE;
                        end
                    end
                    KIND_REG: begin
                        if (w_match) begin
                            w_re     = 1'b0;
                            n_strobe = 1'b1;
                            n_status = ST_PRESENT;
                            n_index  = r_didx;
                            n_value  = r_id;
                            n_last   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            if (w_empty && !r_found) begin
                                n_found = 1'b1;
                                n_pos   = r_didx;
                            end
                            if (w_last) begin
                                n_strobe = 1'b1;
                                n_value  = r_id;
                                n_last   = 1'b1;
                                n_state  = S_IDLE;
                                if (r_found || w_empty) begin
                                    w_we     = 1'b1;
                                    w_waddr  = r_found ? r_pos : r_didx;
                                    w_wdata  = r_id;
                                    n_status = ST_STORED;
                                    n_index  = r_found ? r_pos : r_didx;
                                end else begin
                                    n_status = ST_FULL;
                                    n_index  = '0;
                                end
                            end
                        end
                    end
                    KIND_REMOVE: begin
                        if (r_found) begin
                            w_we    = 1'b1;
                            w_waddr = r_didx - 1'b1;
                            w_wdata = w_rdata;
                            if (w_last) begin
                                n_state = S_CLEAR;
                            end
                        end else if (w_match) begin
                            n_found = 1'b1;
                            n_pos   = r_didx;
                            if (w_last) begin
                                w_we     = 1'b1;
                                w_waddr  = LAST_IDX;
                                w_wdata  = '0;
                                n_strobe = 1'b1;
                                n_status = ST_REMOVED;
                                n_index  = r_didx;
                                n_value  = r_id;
                                n_last   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end else if (w_last) begin
                            n_strobe = 1'b1;
                            n_status = ST_NOTFOUND;
                            n_index  = '0;
                            n_value  = r_id;
                            n_last   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        w_re    = 1'b0;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CLEAR: begin
                w_we     = 1'b1;
                w_waddr  = LAST_IDX;
                w_wdata  = '0;
                n_strobe = 1'b1;
                n_status = ST_REMOVED;
                n_index  = r_pos;
                n_value  = r_id;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_found  <= n_found;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_id     <= n_id;
        r_didx   <= n_didx;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_index  <= n_index;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign w_index_wide = WIDE_W'(r_index);
    assign w_value_wide = WIDE_W'(r_value);

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_slot_index = w_index_wide[INDEX_W-1:0];
    assign o_slot_value = w_value_wide[IDENT_W-1:0];
    assign o_last       = r_last;

    `CIDR_ASSERT_IMP(a_no_rw_clash, w_we && w_re, w_waddr != w_raddr)
    `CIDR_ASSERT_IMP(a_stored_nonzero, o_strobe && (o_status == ST_STORED), o_slot_value != '0)
    `CIDR_ASSERT_IMP(a_single_is_last, o_strobe && (o_status != ST_READ), o_last)
    `CIDR_ASSERT_NXT(a_read_goes_busy, w_accept && (i_kind == KIND_READ), busy)
    `CIDR_ASSERT_NXT(a_unused_silent, w_accept && (i_kind == KIND_NONE), !o_strobe)

endmodule
